### hw/rtl/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Shared constants, the token kind type and the white-space helper of the CSV stream tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int unsigned CharW = 16;

  localparam logic [CharW-1:0] CH_QUOTE    = 16'h0022;
  localparam logic [CharW-1:0] CH_LF       = 16'h000A;
  localparam logic [CharW-1:0] CH_CR       = 16'h000D;
  localparam logic [CharW-1:0] DELIM_RESET = 16'h002C;

  typedef enum logic [1:0] {
    TOK_CHAR  = 2'd0,
    TOK_FIELD = 2'd1,
    TOK_ROW   = 2'd2
  } tok_kind_e;

  // Unicode white space within the basic plane
  function automatic logic is_space(input logic [CharW-1:0] c);
    logic r;
    r = 1'b0;
    if (c inside {16'h0020, [16'h0009:16'h000D], 16'h0085, 16'h00A0, 16'h1680,
                  [16'h2000:16'h200A], 16'h2028, 16'h2029, 16'h202F, 16'h205F,
                  16'h3000}) begin
      r = 1'b1;
    end
    return r;
  endfunction

endpackage

### hw/rtl/cst_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_in_if
// Character channel: one code unit of CSV text per beat.
// ----------------------------------------------------------------------------
interface cst_in_if
  import cst_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

### hw/rtl/cst_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_out_if
// Token channel: one content character, field end or row end per beat.
// ----------------------------------------------------------------------------
interface cst_out_if
  import cst_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       token_kind;
  logic [CharW-1:0] content_char;
  logic             row_is_header;
  logic             row_dropped;
  logic             last_of_run;

  modport source (output valid, output token_kind, output content_char,
                  output row_is_header, output row_dropped, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input content_char,
                  input row_is_header, input row_dropped, input last_of_run,
                  output ready);
endinterface

### hw/rtl/csv_stream_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_stream_tokenizer
// Streaming CSV tokenizer: code units in, content/field-end/row-end tokens out.
// ----------------------------------------------------------------------------
// Takes one code unit per cycle and emits zero, one or two token beats for it
// (a content character, field end or row end, plus a flushing row end when
// end_of_text is set); last_of_run marks the final beat of each code unit.
// A code unit is held in an input register and parsed from there once the
// queue has room, which writes its tokens into a four-entry result queue;
// tokens are offered straight from the queue registers.
// Parsing stalls, and with it the input,
// whenever the queue holds more than two tokens, so the rate is one code unit
// per cycle as long as the sink takes the tokens. The delimiter register may
// be written only while the block is idle.
module csv_stream_tokenizer
  import cst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CharW-1:0] cfg_wdata_i,
  cst_in_if.sink           char_in,
  cst_out_if.source        tok_out
);

  typedef struct packed {
    tok_kind_e        kind;
    logic [CharW-1:0] ch;
    logic             hdr;
    logic             drop;
    logic             last;
  } res_t;

  // configuration
  logic [CharW-1:0] delim_q;

  // input stage
  logic             in_vld_q;
  logic [CharW-1:0] char_q;
  logic             eot_q;
  logic             fire;

  // parser state
  logic in_quotes_q, quote_pending_q, skip_next_lf_q;
  logic field_has_content_q, field_all_blank_q, row_has_fields_q, header_seen_q;
  logic iq, qp, sk, fhc, fab, rhf, hs;

  // parse results
  logic       h_emit, unq, skip_lf, drop_v, hdr_v, t_emit;
  res_t       h_res, t_res, res_a, res_b;
  logic [1:0] n_res;

  // result queue
  res_t       q_mem [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign fire         = in_vld_q && (cnt_q <= 3'd2);
  assign char_in.ready = !in_vld_q || fire;
  assign pop          = tok_out.valid && tok_out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
    end else if (cfg_we_i) begin
      delim_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (char_in.ready) begin
      in_vld_q <= char_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_in.valid && char_in.ready) begin
      char_q <= char_in.char_code;
      eot_q  <= char_in.end_of_text;
    end
  end

  always_comb begin
    iq      = in_quotes_q;
    qp      = quote_pending_q;
    sk      = skip_next_lf_q;
    fhc     = field_has_content_q;
    fab     = field_all_blank_q;
    rhf     = row_has_fields_q;
    hs      = header_seen_q;
    h_emit  = 1'b0;
    h_res   = '{kind: TOK_CHAR, ch: char_q, hdr: 1'b0, drop: 1'b0, last: 1'b0};
    t_emit  = 1'b0;
    t_res   = '{kind: TOK_ROW, ch: '0, hdr: 1'b0, drop: 1'b0, last: 1'b1};
    unq     = 1'b0;
    skip_lf = 1'b0;
    drop_v  = 1'b0;
    hdr_v   = 1'b0;

    if (qp) begin
      qp = 1'b0;
      if (char_q == CH_QUOTE) begin
        // doubled quote: one literal quote
        fhc    = 1'b1;
        fab    = 1'b0;
        h_emit = 1'b1;
      end else begin
        iq  = 1'b0;
        unq = 1'b1;
      end
    end else begin
      if (sk) begin
        sk = 1'b0;
        if (char_q == CH_LF) begin
          skip_lf = 1'b1;
        end
      end
      if (!skip_lf) begin
        if (iq) begin
          if (char_q == CH_QUOTE) begin
            qp = 1'b1;
          end else begin
            fhc    = 1'b1;
            fab    = fab && is_space(char_q);
            h_emit = 1'b1;
          end
        end else begin
          unq = 1'b1;
        end
      end
    end

    if (unq) begin
      if (char_q == CH_QUOTE && !fhc) begin
        iq = 1'b1;
      end else if (char_q == delim_q) begin
        h_emit     = 1'b1;
        h_res.kind = TOK_FIELD;
        h_res.ch   = '0;
        rhf        = 1'b1;
        fhc        = 1'b0;
        fab        = 1'b1;
      end else if (char_q == CH_LF || char_q == CH_CR) begin
        if (char_q == CH_CR) begin
          sk = 1'b1;
        end
        drop_v     = !rhf && fab;
        hdr_v      = !drop_v && !hs;
        hs         = hs || hdr_v;
        h_emit     = 1'b1;
        h_res.kind = TOK_ROW;
        h_res.ch   = '0;
        h_res.hdr  = hdr_v;
        h_res.drop = drop_v;
        fhc        = 1'b0;
        fab        = 1'b1;
        rhf        = 1'b0;
      end else begin
        fhc    = 1'b1;
        fab    = fab && is_space(char_q);
        h_emit = 1'b1;
      end
    end

    if (eot_q) begin
      // flush the open row, then start a fresh text
      if (fhc || rhf) begin
        t_emit     = 1'b1;
        t_res.drop = !rhf && fab;
        t_res.hdr  = !t_res.drop && !hs;
      end
      iq  = 1'b0;
      qp  = 1'b0;
      sk  = 1'b0;
      fhc = 1'b0;
      fab = 1'b1;
      rhf = 1'b0;
      hs  = 1'b0;
    end

    h_res.last = !t_emit;
    res_a      = h_emit ? h_res : t_res;
    res_b      = t_res;
    n_res      = {1'b0, h_emit} + {1'b0, t_emit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q         <= 1'b0;
      quote_pending_q     <= 1'b0;
      skip_next_lf_q      <= 1'b0;
      field_has_content_q <= 1'b0;
      field_all_blank_q   <= 1'b1;
      row_has_fields_q    <= 1'b0;
      header_seen_q       <= 1'b0;
    end else if (fire) begin
      in_quotes_q         <= iq;
      quote_pending_q     <= qp;
      skip_next_lf_q      <= sk;
      field_has_content_q <= fhc;
      field_all_blank_q   <= fab;
      row_has_fields_q    <= rhf;
      header_seen_q       <= hs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && n_res != 2'd0) begin
      q_mem[wr_ptr_q] <= res_a;
    end
    if (fire && n_res == 2'd2) begin
      q_mem[wr_ptr_q + 2'd1] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (fire) begin
        wr_ptr_q <= wr_ptr_q + n_res;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + (fire ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
    end
  end

  assign tok_out.valid         = (cnt_q != 3'd0);
  assign tok_out.token_kind    = q_mem[rd_ptr_q].kind;
  assign tok_out.content_char  = q_mem[rd_ptr_q].ch;
  assign tok_out.row_is_header = q_mem[rd_ptr_q].hdr;
  assign tok_out.row_dropped   = q_mem[rd_ptr_q].drop;
  assign tok_out.last_of_run   = q_mem[rd_ptr_q].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result queue overflow");

  a_pending_quoted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quote_pending_q |-> in_quotes_q)
    else $error("pending quote outside quoted field");

  a_skip_unquoted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_next_lf_q |-> (!in_quotes_q && !quote_pending_q))
    else $error("CR lookahead while quoted");

  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && eot_q) |=> (!in_quotes_q && !header_seen_q && !row_has_fields_q
                         && field_all_blank_q && !field_has_content_q))
    else $error("state not cleared after end of text");

endmodule

### tb/csv_stream_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_tb
// Self-checking bench for the CSV stream tokenizer. Code units are streamed
// in with random gaps and token back-pressure, and a scoreboard that tracks
// the quoting, line-ending and row flags predicts the token beats for each
// accepted code unit. The delimiter is swept across ordinary and corner
// values between idle phases.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer_tb;
  import cst_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    tok_kind_e        kind;
    logic [CharW-1:0] ch;
    logic             hdr;
    logic             drop;
    logic             fin;
  } token_t;

  class tok_scoreboard;
    logic [CharW-1:0] delim;
    bit quoted, quote_held, swallow_lf, has_text, blank, row_open, hdr_done;
    token_t run_toks[$];
    token_t want_toks[$];
    int unsigned mismatches;

    function new();
      delim = DELIM_RESET;
      mismatches = 0;
      clear_text();
    endfunction

    function void clear_text();
      quoted     = 1'b0;
      quote_held = 1'b0;
      swallow_lf = 1'b0;
      has_text   = 1'b0;
      blank      = 1'b1;
      row_open   = 1'b0;
      hdr_done   = 1'b0;
    endfunction

    function void push_tok(tok_kind_e k, logic [CharW-1:0] c, bit h, bit d);
      run_toks.push_back('{k, c, h, d, 1'b0});
    endfunction

    function void add_char(logic [CharW-1:0] c);
      has_text = 1'b1;
      if (!(c inside {16'h0020, [16'h0009:16'h000D], 16'h0085, 16'h00A0, 16'h1680,
                      [16'h2000:16'h200A], 16'h2028, 16'h2029, 16'h202F, 16'h205F,
                      16'h3000})) begin
        blank = 1'b0;
      end
      push_tok(TOK_CHAR, c, 1'b0, 1'b0);
    endfunction

    function void close_row();
      bit drop, hdr;
      drop = !row_open && blank;
      hdr  = !drop && !hdr_done;
      if (hdr) begin
        hdr_done = 1'b1;
      end
      push_tok(TOK_ROW, '0, hdr, drop);
      has_text = 1'b0;
      blank    = 1'b1;
      row_open = 1'b0;
    endfunction

    function void plain_char(logic [CharW-1:0] c);
      if (c == CH_QUOTE && !has_text) begin
        quoted = 1'b1;
      end else if (c == delim) begin
        push_tok(TOK_FIELD, '0, 1'b0, 1'b0);
        row_open = 1'b1;
        has_text = 1'b0;
        blank    = 1'b1;
      end else if (c == CH_LF || c == CH_CR) begin
        if (c == CH_CR) begin
          swallow_lf = 1'b1;
        end
        close_row();
      end else begin
        add_char(c);
      end
    endfunction

    // Predict the token beats of one accepted code unit
    function void note_char(logic [CharW-1:0] c, logic eot);
      bit done;
      done = 1'b0;
      run_toks.delete();
      if (quote_held) begin
        quote_held = 1'b0;
        if (c == CH_QUOTE) begin
          add_char(CH_QUOTE);
        end else begin
          quoted = 1'b0;
          plain_char(c);
        end
        done = 1'b1;
      end else if (swallow_lf) begin
        swallow_lf = 1'b0;
        done = (c == CH_LF);
      end
      if (!done) begin
        if (quoted) begin
          if (c == CH_QUOTE) begin
            quote_held = 1'b1;
          end else begin
            add_char(c);
          end
        end else begin
          plain_char(c);
        end
      end
      if (eot) begin
        if (quote_held) begin
          quote_held = 1'b0;
          quoted = 1'b0;
        end
        if (has_text || row_open) begin
          close_row();
        end
        clear_text();
      end
      if (run_toks.size() > 0) begin
        run_toks[run_toks.size()-1].fin = 1'b1;
      end
      foreach (run_toks[i]) begin
        want_toks.push_back(run_toks[i]);
      end
    endfunction

    function void check_token(logic [1:0] kind, logic [CharW-1:0] ch, logic hdr,
                              logic drop, logic fin);
      token_t want;
      if (want_toks.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: token beat with nothing expected: kind %0d char %h", $realtime,
                   kind, ch);
        end
        return;
      end
      want = want_toks.pop_front();
      if (kind !== want.kind || ch !== want.ch || hdr !== want.hdr ||
          drop !== want.drop || fin !== want.fin) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: token mismatch: expected kind %0d char %h hdr %b drop %b last %b",
                   $realtime, want.kind, want.ch, want.hdr, want.drop, want.fin);
          $display("%0t:                 actual   kind %0d char %h hdr %b drop %b last %b",
                   $realtime, kind, ch, hdr, drop, fin);
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CharW-1:0] cfg_wdata;

  cst_in_if  in_if ();
  cst_out_if out_if ();

  csv_stream_tokenizer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .char_in     (in_if),
    .tok_out     (out_if)
  );

  tok_scoreboard sb;
  bit            calm;
  int unsigned   sink_hold;
  int unsigned   cycles = 0;

  localparam logic [CharW-1:0] Blanks [8] = '{16'h0009, 16'h000B, 16'h0020, 16'h0085,
                                              16'h1680, 16'h200A, 16'h2029, 16'h3000};
  localparam logic [CharW-1:0] DelimSweep [8] = '{16'h003B, 16'h0009, CH_QUOTE, CH_CR,
                                                  CH_LF, 16'hFFFF, 16'h0000, DELIM_RESET};

  // Directed text: {end_of_text, code unit}
  localparam logic [CharW:0] Directed [24] = '{
    // header row a,"b""c" ended by CRLF
    {1'b0, 16'h0061}, {1'b0, DELIM_RESET}, {1'b0, CH_QUOTE}, {1'b0, 16'h0062},
    {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE}, {1'b0, 16'h0063}, {1'b0, CH_QUOTE},
    {1'b0, CH_CR}, {1'b0, CH_LF},
    // whitespace-only row, dropped
    {1'b0, 16'h0020}, {1'b0, 16'h3000}, {1'b0, CH_LF},
    // extreme code units, lone CR
    {1'b0, 16'h0000}, {1'b0, DELIM_RESET}, {1'b0, 16'hFFFF}, {1'b0, CH_CR},
    {1'b0, 16'h0078},
    // unterminated quote flushed at end of text
    {1'b0, DELIM_RESET}, {1'b0, CH_QUOTE}, {1'b1, 16'h00A0},
    // empty quoted field alone, then a blank single-unit text
    {1'b0, CH_QUOTE}, {1'b1, CH_QUOTE}, {1'b1, 16'h2028}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("csv_stream_tokenizer verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_token(out_if.token_kind, out_if.content_char, out_if.row_is_header,
                     out_if.row_dropped, out_if.last_of_run);
    end
  end

  // Token sink: random stalls plus the long hold-off requested by the stimulus
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_char(input logic [CharW-1:0] c, input logic eot);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid       <= 1'b1;
    in_if.char_code   <= c;
    in_if.end_of_text <= eot;
    do @(posedge clk); while (!in_if.ready);
    sb.note_char(c, eot);
  endtask

  // Drop valid and hold until every predicted beat has come out
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.want_toks.size() != 0) @(posedge clk);
  endtask

  task automatic write_delim(input logic [CharW-1:0] d);
    wait_drained();
    // let any beat-less code unit still in flight leave the pipeline
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.delim = d;
  endtask

  // Random texts that mix the characters steering the parser with blanks, printable and arbitrary code units
  task automatic send_texts(input int unsigned n);
    int unsigned sent, len, r;
    logic [CharW-1:0] c;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, 12);
      if (len > n - sent) begin
        len = n - sent;
      end
      for (int unsigned k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          c = sb.delim;
        end else if (r < 22) begin
          c = CH_QUOTE;
        end else if (r < 27) begin
          c = CH_CR;
        end else if (r < 32) begin
          c = CH_LF;
        end else if (r < 42) begin
          c = Blanks[$urandom_range(0, 7)];
        end else if (r < 78) begin
          c = CharW'(16'h0021 + $urandom_range(0, 93));
        end else begin
          c = CharW'($urandom_range(0, 16'hFFFF));
        end
        send_char(c, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    sink_hold = 0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.char_code = '0;
    in_if.end_of_text = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (Directed[i]) begin
      send_char(Directed[i][CharW-1:0], Directed[i][CharW]);
    end

    foreach (DelimSweep[i]) begin
      write_delim(DelimSweep[i]);
      calm = (i == $size(DelimSweep) - 1);
      if (i == 0) begin
        // stall the token side long enough for the input to back up
        sink_hold = 150;
      end
      send_texts(10);
      if (i == 1) begin
        wait_drained();
      end
      send_texts(10);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.want_toks.size() == 0) begin
      $display("csv_stream_tokenizer verification clean");
    end else begin
      $display("csv_stream_tokenizer verification failed");
    end
    $finish;
  end

endmodule
